// ===== design/ray_triangle_intersect_assert.svh =====
// ----------------------------------------------------------------------------
// ray_triangle_intersect_assert.svh
// assertion macros for the ray-triangle intersection rtl
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`ifndef ASSERT_OFF
// checked only out of reset
`define RTI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// checked at every edge, reset included
`define RTI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define RTI_ASSERT(lbl, prop, msg)
`define RTI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/rti_pkg.sv =====
// ----------------------------------------------------------------------------
// rti_pkg
// types and widths of the ray-triangle intersection pipeline
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int COORD_W = 32;
    localparam int TRI_W   = 8;
    localparam int SLOT_W  = 2;
    localparam int CORNERS = 3;
    localparam int EPS_W   = 63;
    localparam int DOT_W   = 104;
    localparam int MAG_W   = DOT_W - 1;
    localparam int QUOT_W  = 33;
    localparam int DIV_LAT = QUOT_W + 2;

    localparam logic [EPS_W-1:0] EPS_RESET = 63'd2814750;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_TEST = 1'b1
    } mode_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } vec3_t;

    typedef struct packed {
        mode_t               mode;
        logic [TRI_W-1:0]    triangle_index;
        logic [SLOT_W-1:0]   vertex_slot;
        coord_t              pos_x;
        coord_t              pos_y;
        coord_t              pos_z;
        coord_t              dir_x;
        coord_t              dir_y;
        coord_t              dir_z;
        coord_t              t_min;
        coord_t              t_max;
    } in_item_t;

    typedef struct packed {
        logic   hit;
        coord_t bary_u;
        coord_t bary_v;
        coord_t hit_distance;
    } out_item_t;

    function automatic coord_t vec_comp(vec3_t v, logic [1:0] c);
        coord_t r;
        case (c)
            2'd0:    r = v.x;
            2'd1:    r = v.y;
            default: r = v.z;
        endcase
        return r;
    endfunction

endpackage

// ===== design/rti_divider.sv =====
// ----------------------------------------------------------------------------
// rti_divider
// pipelined restoring divider, one quotient bit per stage, saturating result
// ----------------------------------------------------------------------------
module rti_divider #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 en,
    input  rti_pkg::mag_t        num_mag,
    input  rti_pkg::mag_t        den,
    input  logic                 neg,
    output rti_pkg::coord_t      quot
);

    localparam int MAG_W   = rti_pkg::MAG_W;
    localparam int QUOT_W  = rti_pkg::QUOT_W;
    localparam int COORD_W = rti_pkg::COORD_W;
    localparam int REM_W   = MAG_W + QUOT_W + 1;

    logic [REM_W-1:0]  rem_reg [QUOT_W+1];
    logic [MAG_W-1:0]  den_reg [QUOT_W+1];
    logic [QUOT_W-1:0] q_reg   [QUOT_W+1];
    logic              ovf_reg [QUOT_W+1];
    logic              neg_reg [QUOT_W+1];
    logic [REM_W:0]    diff    [QUOT_W+1];

    logic [REM_W-1:0]  num_sh;
    logic [REM_W-1:0]  den_top;
    logic [QUOT_W-1:0] q_fin;
    logic [QUOT_W-1:0] lim;
    logic              sat;
    rti_pkg::coord_t   quot_next;
    rti_pkg::coord_t   quot_reg;

    assign num_sh  = REM_W'(num_mag) << FRAC_BITS;
    assign den_top = REM_W'(den) << QUOT_W;

    // trial subtract of den shifted to the bit that stage k decides
    always_comb begin
        diff[0] = '0;
        for (int k = 1; k <= QUOT_W; k++) begin
            diff[k] = (REM_W+1)'(rem_reg[k-1])
                    - ((REM_W+1)'(den_reg[k-1]) << (QUOT_W - k));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num_sh;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= num_sh >= den_top;
            neg_reg[0] <= neg;
            for (int k = 1; k <= QUOT_W; k++) begin
                rem_reg[k] <= diff[k][REM_W] ? rem_reg[k-1] : diff[k][REM_W-1:0];
                q_reg[k]   <= {q_reg[k-1][QUOT_W-2:0], !diff[k][REM_W]};
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
            quot_reg <= quot_next;
        end
    end

    // saturate to the signed 32-bit range
    always_comb begin
        q_fin = q_reg[QUOT_W];
        lim   = (QUOT_W'(1) << (COORD_W - 1)) - (neg_reg[QUOT_W] ? QUOT_W'(0) : QUOT_W'(1));
        sat   = ovf_reg[QUOT_W] || (q_fin > lim);
        if (neg_reg[QUOT_W]) begin
            quot_next = sat ? {1'b1, {(COORD_W-1){1'b0}}} : COORD_W'(QUOT_W'(0) - q_fin);
        end else begin
            quot_next = sat ? {1'b0, {(COORD_W-1){1'b1}}} : q_fin[COORD_W-1:0];
        end
    end

    assign quot = quot_reg;

endmodule

// ===== design/ray_triangle_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// moller-trumbore ray-triangle test against a local triangle store
// ----------------------------------------------------------------------------
// usage
//   s_valid/s_ready/s_item carry load and test items; a transfer happens when
//   valid and ready are both high. a load (mode 0) writes one corner of one
//   triangle and gives no result; a test (mode 1) gives one result on
//   m_valid/m_ready/m_item. cfg_we/cfg_wdata write the determinant epsilon
//   and must only be used while the block is idle.
//   throughput: one item per cycle unless the receiver stalls. the datapath
//   is a 43-stage pipeline: eight stages for the store read, edges, cross
//   products, split dot products and magnitudes, then three 35-stage
//   dividers (one quotient bit per stage) for u, v and t, then the output
//   register. a load is visible to a test that follows in the very next
//   cycle.
//   reset clears all valid bits, including those of the output and skid
//   registers, and loads the epsilon reset value; the vertex store is not
//   cleared and a corner must be loaded before a test reads it.
//   when the receiver stalls, the pipeline keeps running until one result
//   is parked in the skid register; only then s_ready drops and the whole
//   pipeline holds its contents.
// ----------------------------------------------------------------------------
`include "ray_triangle_intersect_assert.svh"

module ray_triangle_intersect #(
    parameter int TRIANGLES = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  rti_pkg::in_item_t           s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output rti_pkg::out_item_t          m_item,
    input  logic                        cfg_we,
    input  logic [rti_pkg::EPS_W-1:0]   cfg_wdata
);

    localparam int COORD_W = rti_pkg::COORD_W;
    localparam int SLOT_W  = rti_pkg::SLOT_W;
    localparam int MAG_W   = rti_pkg::MAG_W;
    localparam int DOT_W   = rti_pkg::DOT_W;
    localparam int DIV_LAT = rti_pkg::DIV_LAT;
    localparam int TRI_AW  = (TRIANGLES > 1) ? $clog2(TRIANGLES) : 1;
    localparam int EDGE_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int SPLIT_W = 34;
    localparam int LO_W    = EDGE_W + SPLIT_W + 1;
    localparam int HI_W    = EDGE_W + CROSS_W - SPLIT_W;
    localparam int PRE_ST  = 8;

    localparam rti_pkg::coord_t ONE_Q = rti_pkg::coord_t'(1) << FRAC_BITS;

    typedef logic signed [EDGE_W-1:0]  edge_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [CROSS_W-1:0] cross_t;
    typedef logic signed [LO_W-1:0]    lo_t;
    typedef logic signed [HI_W-1:0]    hi_t;
    typedef logic signed [DOT_W-1:0]   dot_t;

    typedef struct packed {
        logic            inr;
        rti_pkg::coord_t t_min;
        rti_pkg::coord_t t_max;
    } side_t;

    typedef struct packed {
        logic            ok;
        rti_pkg::coord_t t_min;
        rti_pkg::coord_t t_max;
    } post_t;

    // handshake and control
    logic                 adv;
    logic                 accept;
    logic                 test_acc;
    logic                 load_acc;
    logic                 tri_in_range;
    logic [TRI_AW-1:0]    tri_addr;
    rti_pkg::vec3_t       wr_vtx;
    logic [rti_pkg::EPS_W-1:0] eps_reg;

    rti_pkg::coord_t      in_pos [3];
    rti_pkg::coord_t      in_dir [3];
    rti_pkg::vec3_t       corner_q [3];

    // pipeline valid bits and side data up to the dividers
    logic                 pre_vld_reg  [PRE_ST];
    side_t                pre_side_reg [PRE_ST];

    rti_pkg::coord_t      s1_org_reg [3];
    rti_pkg::coord_t      s1_dir_reg [3];
    edge_t                s2_e1_reg [3];
    edge_t                s2_e2_reg [3];
    edge_t                s2_tv_reg [3];
    edge_t                s2_dir_reg [3];
    prod_t                s3_pp_pos_reg [3];
    prod_t                s3_pp_neg_reg [3];
    prod_t                s3_qp_pos_reg [3];
    prod_t                s3_qp_neg_reg [3];
    edge_t                s3_e1_reg [3];
    edge_t                s3_e2_reg [3];
    edge_t                s3_tv_reg [3];
    edge_t                s3_dir_reg [3];
    cross_t               s4_pv_reg [3];
    cross_t               s4_qv_reg [3];
    edge_t                s4_e1_reg [3];
    edge_t                s4_e2_reg [3];
    edge_t                s4_tv_reg [3];
    edge_t                s4_dir_reg [3];
    edge_t                dot_a [4][3];
    cross_t               dot_b [4][3];
    lo_t                  s5_lo_reg [4][3];
    hi_t                  s5_hi_reg [4][3];
    dot_t                 s6_full_reg [4][3];
    dot_t                 s7_dot_reg [4];
    rti_pkg::mag_t        s8_mag_reg [4];
    logic                 s8_neg_reg [3];
    logic                 s8_nz_reg;

    // side data alongside the dividers
    logic                 sb_vld_reg  [DIV_LAT];
    post_t                sb_post_reg [DIV_LAT];
    rti_pkg::coord_t      quot_q [3];

    // result and output stage
    logic                 p_valid;
    logic                 p_hit;
    logic signed [COORD_W:0] uv_sum;
    rti_pkg::out_item_t   p_item;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    rti_pkg::out_item_t   m_item_reg;
    rti_pkg::out_item_t   m_item_next;
    rti_pkg::out_item_t   skid_item_reg;
    rti_pkg::out_item_t   skid_item_next;

    // the pipeline moves as a whole until the skid register is occupied
    assign adv      = !skid_valid_reg;
    assign s_ready  = adv;
    assign accept   = s_valid && s_ready;
    assign test_acc = accept && (s_item.mode == rti_pkg::MODE_TEST);
    assign load_acc = accept && (s_item.mode == rti_pkg::MODE_LOAD);

    assign tri_in_range = 32'(s_item.triangle_index) < TRIANGLES;
    assign tri_addr     = TRI_AW'(s_item.triangle_index);
    assign wr_vtx       = '{z: s_item.pos_z, y: s_item.pos_y, x: s_item.pos_x};

    assign in_pos[0] = s_item.pos_x;
    assign in_pos[1] = s_item.pos_y;
    assign in_pos[2] = s_item.pos_z;
    assign in_dir[0] = s_item.dir_x;
    assign in_dir[1] = s_item.dir_y;
    assign in_dir[2] = s_item.dir_z;

    // epsilon register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= rti_pkg::EPS_RESET;
        end else if (cfg_we) begin
            eps_reg <= cfg_wdata;
        end
    end

    // vertex store: one bank per corner so a test reads all three at once;
    // a load writes only the bank of its slot, slot 3 matches no bank
    for (genvar b = 0; b < rti_pkg::CORNERS; b++) begin : g_bank
        rti_pkg::vec3_t mem [TRIANGLES];
        rti_pkg::vec3_t rd_reg;

        always_ff @(posedge aclk) begin
            if (load_acc && tri_in_range && (s_item.vertex_slot == SLOT_W'(b))) begin
                mem[tri_addr] <= wr_vtx;
            end
            if (adv) begin
                rd_reg <= mem[tri_addr];
            end
        end

        assign corner_q[b] = rd_reg;
    end

    // valid bits of the front stages; loads enter as bubbles
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PRE_ST; i++) begin
                pre_vld_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            pre_vld_reg[0] <= test_acc;
            for (int i = 1; i < PRE_ST; i++) begin
                pre_vld_reg[i] <= pre_vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pre_side_reg[0] <= '{inr: tri_in_range, t_min: s_item.t_min, t_max: s_item.t_max};
            for (int i = 1; i < PRE_ST; i++) begin
                pre_side_reg[i] <= pre_side_reg[i-1];
            end
        end
    end

    // stage 1: ray capture (corners come from the store banks)
    // stage 2: edges and origin offset
    // stage 3: cross product partial products
    // stage 4: pvec = dir x e2, qvec = tvec x e1
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                s1_org_reg[c] <= in_pos[c];
                s1_dir_reg[c] <= in_dir[c];

                s2_e1_reg[c]  <= edge_t'(rti_pkg::vec_comp(corner_q[1], 2'(c)))
                               - edge_t'(rti_pkg::vec_comp(corner_q[0], 2'(c)));
                s2_e2_reg[c]  <= edge_t'(rti_pkg::vec_comp(corner_q[2], 2'(c)))
                               - edge_t'(rti_pkg::vec_comp(corner_q[0], 2'(c)));
                s2_tv_reg[c]  <= edge_t'(s1_org_reg[c])
                               - edge_t'(rti_pkg::vec_comp(corner_q[0], 2'(c)));
                s2_dir_reg[c] <= edge_t'(s1_dir_reg[c]);

                s3_pp_pos_reg[c] <= s2_dir_reg[(c+1)%3] * s2_e2_reg[(c+2)%3];
                s3_pp_neg_reg[c] <= s2_dir_reg[(c+2)%3] * s2_e2_reg[(c+1)%3];
                s3_qp_pos_reg[c] <= s2_tv_reg[(c+1)%3] * s2_e1_reg[(c+2)%3];
                s3_qp_neg_reg[c] <= s2_tv_reg[(c+2)%3] * s2_e1_reg[(c+1)%3];
                s3_e1_reg[c]     <= s2_e1_reg[c];
                s3_e2_reg[c]     <= s2_e2_reg[c];
                s3_tv_reg[c]     <= s2_tv_reg[c];
                s3_dir_reg[c]    <= s2_dir_reg[c];

                s4_pv_reg[c]  <= cross_t'(s3_pp_pos_reg[c]) - cross_t'(s3_pp_neg_reg[c]);
                s4_qv_reg[c]  <= cross_t'(s3_qp_pos_reg[c]) - cross_t'(s3_qp_neg_reg[c]);
                s4_e1_reg[c]  <= s3_e1_reg[c];
                s4_e2_reg[c]  <= s3_e2_reg[c];
                s4_tv_reg[c]  <= s3_tv_reg[c];
                s4_dir_reg[c] <= s3_dir_reg[c];
            end
        end
    end

    // operands of the four dot products: det, u, v and t numerators
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            dot_a[0][c] = s4_e1_reg[c];
            dot_b[0][c] = s4_pv_reg[c];
            dot_a[1][c] = s4_tv_reg[c];
            dot_b[1][c] = s4_pv_reg[c];
            dot_a[2][c] = s4_dir_reg[c];
            dot_b[2][c] = s4_qv_reg[c];
            dot_a[3][c] = s4_e2_reg[c];
            dot_b[3][c] = s4_qv_reg[c];
        end
    end

    // stage 5: each wide product split into two narrow ones
    // stage 6: partial products recombined
    // stage 7: dot product sums
    // stage 8: magnitudes and quotient signs
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int q = 0; q < 4; q++) begin
                for (int c = 0; c < 3; c++) begin
                    s5_lo_reg[q][c] <= dot_a[q][c]
                                     * $signed({1'b0, dot_b[q][c][SPLIT_W-1:0]});
                    s5_hi_reg[q][c] <= dot_a[q][c]
                                     * $signed(dot_b[q][c][CROSS_W-1:SPLIT_W]);
                    s6_full_reg[q][c] <= (dot_t'(s5_hi_reg[q][c]) <<< SPLIT_W)
                                       + dot_t'(s5_lo_reg[q][c]);
                end
                s7_dot_reg[q] <= s6_full_reg[q][0] + s6_full_reg[q][1] + s6_full_reg[q][2];
                s8_mag_reg[q] <= MAG_W'(s7_dot_reg[q][DOT_W-1] ? -s7_dot_reg[q]
                                                               : s7_dot_reg[q]);
            end
            // a negative det flips the sign of every numerator
            for (int q = 1; q < 4; q++) begin
                s8_neg_reg[q-1] <= s7_dot_reg[q][DOT_W-1] ^ s7_dot_reg[0][DOT_W-1];
            end
            s8_nz_reg <= s7_dot_reg[0] != '0;
        end
    end

    // u, v and t quotients; det magnitude is the shared divisor
    for (genvar j = 0; j < 3; j++) begin : g_div
        rti_divider #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .aclk    (aclk),
            .en      (adv),
            .num_mag (s8_mag_reg[j+1]),
            .den     (s8_mag_reg[0]),
            .neg     (s8_neg_reg[j]),
            .quot    (quot_q[j])
        );
    end

    // side data kept in step with the divider stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                sb_vld_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            sb_vld_reg[0] <= pre_vld_reg[PRE_ST-1];
            for (int i = 1; i < DIV_LAT; i++) begin
                sb_vld_reg[i] <= sb_vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // parallel ray or missing triangle: a miss whatever the quotients say
            sb_post_reg[0] <= '{
                ok:    pre_side_reg[PRE_ST-1].inr && s8_nz_reg
                       && (s8_mag_reg[0] >= MAG_W'(eps_reg)),
                t_min: pre_side_reg[PRE_ST-1].t_min,
                t_max: pre_side_reg[PRE_ST-1].t_max
            };
            for (int i = 1; i < DIV_LAT; i++) begin
                sb_post_reg[i] <= sb_post_reg[i-1];
            end
        end
    end

    // hit decision on the saturated quotients
    always_comb begin
        p_valid = sb_vld_reg[DIV_LAT-1];
        uv_sum  = (COORD_W+1)'(quot_q[0]) + (COORD_W+1)'(quot_q[1]);
        p_hit   = sb_post_reg[DIV_LAT-1].ok
                  && (quot_q[0] >= 0) && (quot_q[0] <= ONE_Q)
                  && (quot_q[1] >= 0)
                  && (uv_sum <= (COORD_W+1)'(ONE_Q))
                  && (quot_q[2] >= sb_post_reg[DIV_LAT-1].t_min)
                  && (quot_q[2] <= sb_post_reg[DIV_LAT-1].t_max);
        if (p_hit) begin
            p_item = '{hit: 1'b1, bary_u: quot_q[0], bary_v: quot_q[1],
                       hit_distance: quot_q[2]};
        end else begin
            p_item = '0;
        end
    end

    // output register with one skid entry behind it
    always_comb begin
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        m_item_next     = m_item_reg;
        skid_item_next  = skid_item_reg;
        if (skid_valid_reg) begin
            if (m_ready) begin
                m_item_next     = skid_item_reg;
                skid_valid_next = 1'b0;
            end
        end else if (p_valid) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_next = 1'b1;
                m_item_next  = p_item;
            end else begin
                skid_valid_next = 1'b1;
                skid_item_next  = p_item;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg    <= m_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // checks
    `RTI_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_valid_reg && !skid_valid_reg, "output not empty after reset")
    `RTI_ASSERT(a_skid_needs_out, skid_valid_reg |-> m_valid_reg, "skid entry behind an empty output")
    `RTI_ASSERT(a_skid_on_stall, $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_ready), "skid filled without a stall")
    `RTI_ASSERT(a_miss_is_zero, m_valid_reg && !m_item_reg.hit |-> m_item_reg.bary_u == '0 && m_item_reg.bary_v == '0 && m_item_reg.hit_distance == '0, "miss with nonzero fields")
    `RTI_ASSERT(a_hit_bary_pos, m_valid_reg && m_item_reg.hit |-> !m_item_reg.bary_u[COORD_W-1] && !m_item_reg.bary_v[COORD_W-1], "hit with negative barycentric")

endmodule
